/* src/brr_pkg.sv */
`timescale 1ns / 1ps
// brr_pkg: types, sizes and codes shared by the bilinear RGBA resizer.
// No dependencies.
package brr_pkg;

   localparam int MAX_SOURCE_WIDTH  = 128;
   localparam int MAX_SOURCE_HEIGHT = 128;

   // column / row index widths inside the pixel store
   localparam int XI_W = $clog2(MAX_SOURCE_WIDTH);
   localparam int YI_W = $clog2(MAX_SOURCE_HEIGHT);
   // four parity banks, each holds one quarter of the store
   localparam int BANK_AW    = (XI_W - 1) + (YI_W - 1);
   localparam int BANK_DEPTH = 2 ** BANK_AW;
   localparam int PIX_W      = 32;

   localparam int SRC_W  = 8;              // source size register
   localparam int DIM_W  = 12;             // target size / coordinates
   localparam int DEN_W  = DIM_W + 1;      // 2*dst
   localparam int ANUM_W = DEN_W + SRC_W;  // (2x+1)*src
   localparam int Q_W    = 8;              // axis quotient
   localparam int TOP_W  = 8 + DEN_W;      // one horizontal blend
   localparam int DD_W   = 2 * DEN_W;      // dx*dy
   localparam int SUM_W  = TOP_W + DEN_W;  // full blend
   localparam int OQ_W   = 8;              // output quotient

   // pipeline stage positions
   localparam int ST_IN    = 0;
   localparam int ST_PREP  = 1;
   localparam int ST_ADIV  = 2;
   localparam int ST_AXIS  = ST_ADIV + Q_W;
   localparam int ST_READ  = ST_AXIS + 1;
   localparam int ST_BLEND = ST_READ + 1;
   localparam int ST_SUM   = ST_BLEND + 1;
   localparam int ST_ODIV  = ST_SUM + 1;
   localparam int N_STAGES = ST_ODIV + OQ_W;

   typedef enum logic [1:0] {
      REG_SOURCE_WIDTH,
      REG_SOURCE_HEIGHT,
      REG_TARGET_WIDTH,
      REG_TARGET_HEIGHT
   } reg_index_type;

   typedef enum logic {
      FUNC_LOAD,
      FUNC_COMPUTE
   } func_type;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   typedef struct packed {
      func_type   func;
      logic [11:0] pos_x;
      logic [11:0] pos_y;
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
      logic [7:0] in_alpha;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
      logic       status;
   } rsp_type;

   typedef struct packed {
      func_type                   func;
      logic                       load_en;
      logic                       oob;
      logic [DIM_W-1:0]           px;
      logic [DIM_W-1:0]           py;
      logic [PIX_W-1:0]           pix;
      logic                       negx;
      logic                       negy;
      logic [ANUM_W-1:0]          remx;
      logic [ANUM_W-1:0]          remy;
      logic [DEN_W-1:0]           denx;
      logic [DEN_W-1:0]           deny;
      logic [Q_W-1:0]             qx;
      logic [Q_W-1:0]             qy;
      logic [XI_W-1:0]            x0;
      logic [XI_W-1:0]            x1;
      logic [YI_W-1:0]            y0;
      logic [YI_W-1:0]            y1;
      logic [DEN_W-1:0]           fx;
      logic [DEN_W-1:0]           fy;
      logic [3:0][TOP_W-1:0]      top;
      logic [3:0][TOP_W-1:0]      bot;
      logic [DD_W-1:0]            dd;
      logic [3:0][SUM_W-1:0]      sum;
      logic [3:0][OQ_W-1:0]       quo;
   } pipe_type;

endpackage

/* src/bilinear_rgba_resize.sv */
`timescale 1ns / 1ps
// bilinear_rgba_resize: top level of the bilinear RGBA resizer.
// Uses brr_pkg and four brr_ram parity banks.
//
// Usage
//   Input channel req_*: one item per cycle unless stalled. A load item
//   (func load) writes one RGBA pixel into the source store; loads outside
//   the source size are dropped. A compute item names a destination pixel and
//   yields one rsp item: the bilinear blend with half-pixel centers, or status
//   1 with zero colors if the coordinate lies outside the target size.
//   Config port (APB): source width/height at 0x0/0x4, target width/height
//   at 0x8/0xC (0 = same as source). Write only while no item is in flight.
//   Throughput: one item per cycle unless rsp_stall freezes the pipeline;
//   the pipeline is 22 stages (two 8-step restoring dividers, one per axis
//   pair and one for the final normalization) around a single read/write
//   access of the four parity-banked pixel memories.
//   Neighbor columns x0/x1 always differ in parity (or coincide), same for
//   rows, so distinct bilinear taps land in distinct banks.
//   Loads and reads happen in order at one stage, so a compute always sees
//   every load accepted before it.
//   Reset: clears all valid bits and the size registers (1x1 source, 0x0
//   target). Store contents stay undefined until loaded.
//   Stall: when rsp_stall holds a waiting result, the whole pipeline
//   freezes and req_stall rises; with the output empty req_stall is low.
module bilinear_rgba_resize (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  brr_pkg::req_type req_item,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output brr_pkg::rsp_type rsp_item,
   input  logic            psel,
   input  logic            penable,
   input  logic            pwrite,
   input  logic [3:0]      paddr,
   input  logic [31:0]     pwdata,
   output logic [31:0]     prdata,
   output logic            pready
);
   import brr_pkg::*;

   // config registers
   logic [SRC_W-1:0] source_width_ff, source_height_ff;
   logic [DIM_W-1:0] target_width_ff, target_height_ff;
   reg_index_type    csr_index;

   // effective sizes
   logic [SRC_W-1:0] sw, sh;
   logic [DIM_W-1:0] dw, dh;

   // pipeline
   pipe_type pipe_ff [N_STAGES];
   pipe_type pipe_in [N_STAGES];
   logic     valid_ff [N_STAGES];
   logic     advance;

   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   // memory ports
   logic                 bank_en [4];
   logic                 bank_we [4];
   logic [BANK_AW-1:0]   bank_addr [4];
   logic [PIX_W-1:0]     bank_rdata [4];

   assign csr_index = reg_index_type'(paddr[3:2]);
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         source_width_ff  <= SRC_W'(1);
         source_height_ff <= SRC_W'(1);
         target_width_ff  <= '0;
         target_height_ff <= '0;
      end else if (psel && penable && pwrite) begin
         unique case (csr_index)
            REG_SOURCE_WIDTH:  source_width_ff  <= pwdata[SRC_W-1:0];
            REG_SOURCE_HEIGHT: source_height_ff <= pwdata[SRC_W-1:0];
            REG_TARGET_WIDTH:  target_width_ff  <= pwdata[DIM_W-1:0];
            REG_TARGET_HEIGHT: target_height_ff <= pwdata[DIM_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_SOURCE_WIDTH:  prdata = 32'(source_width_ff);
         REG_SOURCE_HEIGHT: prdata = 32'(source_height_ff);
         REG_TARGET_WIDTH:  prdata = 32'(target_width_ff);
         REG_TARGET_HEIGHT: prdata = 32'(target_height_ff);
      endcase
   end

   // zero acts as one, oversize clamps to the store size
   always_comb begin
      if (source_width_ff == '0) begin
         sw = SRC_W'(1);
      end else if (32'(source_width_ff) > MAX_SOURCE_WIDTH) begin
         sw = SRC_W'(MAX_SOURCE_WIDTH);
      end else begin
         sw = source_width_ff;
      end
      if (source_height_ff == '0) begin
         sh = SRC_W'(1);
      end else if (32'(source_height_ff) > MAX_SOURCE_HEIGHT) begin
         sh = SRC_W'(MAX_SOURCE_HEIGHT);
      end else begin
         sh = source_height_ff;
      end
      dw = (target_width_ff  != '0) ? target_width_ff  : DIM_W'(sw);
      dh = (target_height_ff != '0) ? target_height_ff : DIM_W'(sh);
   end

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // stage logic
   always_comb begin
      logic [ANUM_W-1:0] prodx, prody, trial;
      logic [ANUM_W:0]   numx, numy;
      logic [Q_W-1:0]    basex, basey;
      logic [Q_W:0]      nx, ny;
      logic [7:0]        ca, cb, cd, ce;
      logic [PIX_W-1:0]  p00, p10, p01, p11;
      logic [SUM_W-1:0]  otrial;
      pipe_type          p;
      int                k;

      // input capture
      pipe_in[ST_IN]       = '0;
      pipe_in[ST_IN].func  = req_item.func;
      pipe_in[ST_IN].px    = req_item.pos_x;
      pipe_in[ST_IN].py    = req_item.pos_y;
      pipe_in[ST_IN].pix   = {req_item.in_alpha, req_item.in_blue,
                              req_item.in_green, req_item.in_red};

      for (int i = 1; i < N_STAGES; i++) begin
         pipe_in[i] = pipe_ff[i-1];
      end

      // prep: numerators, denominators, range checks
      p     = pipe_ff[ST_PREP-1];
      prodx = ANUM_W'({p.px, 1'b1}) * ANUM_W'(sw);
      prody = ANUM_W'({p.py, 1'b1}) * ANUM_W'(sh);
      numx  = {1'b0, prodx} - (ANUM_W+1)'(dw);
      numy  = {1'b0, prody} - (ANUM_W+1)'(dh);
      pipe_in[ST_PREP].negx    = numx[ANUM_W];
      pipe_in[ST_PREP].negy    = numy[ANUM_W];
      pipe_in[ST_PREP].remx    = numx[ANUM_W-1:0];
      pipe_in[ST_PREP].remy    = numy[ANUM_W-1:0];
      pipe_in[ST_PREP].denx    = {dw, 1'b0};
      pipe_in[ST_PREP].deny    = {dh, 1'b0};
      pipe_in[ST_PREP].qx      = '0;
      pipe_in[ST_PREP].qy      = '0;
      pipe_in[ST_PREP].oob     = (p.px >= dw) || (p.py >= dh);
      pipe_in[ST_PREP].load_en = (p.func == FUNC_LOAD) && (p.px < DIM_W'(sw))
                                 && (p.py < DIM_W'(sh));

      // axis division, one quotient bit per stage
      for (int j = 0; j < Q_W; j++) begin
         k     = Q_W - 1 - j;
         p     = pipe_ff[ST_ADIV+j-1];
         trial = ANUM_W'(p.denx) << k;
         if (p.remx >= trial) begin
            pipe_in[ST_ADIV+j].remx  = p.remx - trial;
            pipe_in[ST_ADIV+j].qx[k] = 1'b1;
         end
         trial = ANUM_W'(p.deny) << k;
         if (p.remy >= trial) begin
            pipe_in[ST_ADIV+j].remy  = p.remy - trial;
            pipe_in[ST_ADIV+j].qy[k] = 1'b1;
         end
      end

      // axis finish: clamp, fractions, neighbor indexes
      p = pipe_ff[ST_AXIS-1];
      if (p.negx) begin
         basex = '0;
         pipe_in[ST_AXIS].fx = '0;
      end else if (p.qx >= Q_W'(sw)) begin
         basex = Q_W'(sw) - Q_W'(1);
         pipe_in[ST_AXIS].fx = p.denx;
      end else begin
         basex = p.qx;
         pipe_in[ST_AXIS].fx = p.remx[DEN_W-1:0];
      end
      if (p.negy) begin
         basey = '0;
         pipe_in[ST_AXIS].fy = '0;
      end else if (p.qy >= Q_W'(sh)) begin
         basey = Q_W'(sh) - Q_W'(1);
         pipe_in[ST_AXIS].fy = p.deny;
      end else begin
         basey = p.qy;
         pipe_in[ST_AXIS].fy = p.remy[DEN_W-1:0];
      end
      nx = {1'b0, basex} + (Q_W+1)'(1);
      ny = {1'b0, basey} + (Q_W+1)'(1);
      pipe_in[ST_AXIS].x0 = basex[XI_W-1:0];
      pipe_in[ST_AXIS].y0 = basey[YI_W-1:0];
      pipe_in[ST_AXIS].x1 = (nx < (Q_W+1)'(sw)) ? nx[XI_W-1:0] : basex[XI_W-1:0];
      pipe_in[ST_AXIS].y1 = (ny < (Q_W+1)'(sh)) ? ny[YI_W-1:0] : basey[YI_W-1:0];

      // blend rows (memory data belongs to the item in ST_READ)
      p   = pipe_ff[ST_READ];
      p00 = bank_rdata[{p.y0[0], p.x0[0]}];
      p10 = bank_rdata[{p.y0[0], p.x1[0]}];
      p01 = bank_rdata[{p.y1[0], p.x0[0]}];
      p11 = bank_rdata[{p.y1[0], p.x1[0]}];
      for (int c = 0; c < 4; c++) begin
         ca = p00[8*c +: 8];
         cb = p10[8*c +: 8];
         cd = p01[8*c +: 8];
         ce = p11[8*c +: 8];
         pipe_in[ST_BLEND].top[c] = TOP_W'(ca) * TOP_W'(p.denx - p.fx)
                                  + TOP_W'(cb) * TOP_W'(p.fx);
         pipe_in[ST_BLEND].bot[c] = TOP_W'(cd) * TOP_W'(p.denx - p.fx)
                                  + TOP_W'(ce) * TOP_W'(p.fx);
      end
      pipe_in[ST_BLEND].dd = DD_W'(p.denx) * DD_W'(p.deny);

      // blend columns, plus half the denominator for round half up
      p = pipe_ff[ST_SUM-1];
      for (int c = 0; c < 4; c++) begin
         pipe_in[ST_SUM].sum[c] = SUM_W'(p.top[c]) * SUM_W'(p.deny - p.fy)
                                + SUM_W'(p.bot[c]) * SUM_W'(p.fy)
                                + SUM_W'(p.dd >> 1);
         pipe_in[ST_SUM].quo[c] = '0;
      end

      // final normalization, one bit per stage on all four channels
      for (int j = 0; j < OQ_W; j++) begin
         k      = OQ_W - 1 - j;
         p      = pipe_ff[ST_ODIV+j-1];
         otrial = SUM_W'(p.dd) << k;
         for (int c = 0; c < 4; c++) begin
            if (p.sum[c] >= otrial) begin
               pipe_in[ST_ODIV+j].sum[c]    = p.sum[c] - otrial;
               pipe_in[ST_ODIV+j].quo[c][k] = 1'b1;
            end
         end
      end

      // result
      p = pipe_ff[N_STAGES-1];
      if (p.oob) begin
         rsp_in = '{out_red: '0, out_green: '0, out_blue: '0, out_alpha: '0,
                    status: STATUS_RANGE};
      end else begin
         rsp_in = '{out_red: p.quo[0], out_green: p.quo[1], out_blue: p.quo[2],
                    out_alpha: p.quo[3], status: STATUS_OK};
      end
   end

   // bank access: loads write one bank, computes read all four
   always_comb begin
      pipe_type          a;
      logic [XI_W-1:0]   xs;
      logic [YI_W-1:0]   ys;
      logic [1:0]        lb;
      a  = pipe_ff[ST_AXIS];
      lb = {a.py[0], a.px[0]};
      for (int b = 0; b < 4; b++) begin
         xs = (a.x0[0] == b[0]) ? a.x0 : a.x1;
         ys = (a.y0[0] == b[1]) ? a.y0 : a.y1;
         if (a.func == FUNC_LOAD) begin
            bank_we[b]   = a.load_en && (lb == 2'(b));
            bank_en[b]   = advance && valid_ff[ST_AXIS] && bank_we[b];
            bank_addr[b] = {a.py[YI_W-1:1], a.px[XI_W-1:1]};
         end else begin
            bank_we[b]   = 1'b0;
            bank_en[b]   = advance && valid_ff[ST_AXIS];
            bank_addr[b] = {ys[YI_W-1:1], xs[XI_W-1:1]};
         end
      end
   end

   for (genvar b = 0; b < 4; b++) begin : g_bank
      brr_ram #(.WIDTH(PIX_W), .DEPTH(BANK_DEPTH)) u_ram (
         .clock (clock),
         .en    (bank_en[b]),
         .we    (bank_we[b]),
         .addr  (bank_addr[b]),
         .wdata (pipe_ff[ST_AXIS].pix),
         .rdata (bank_rdata[b])
      );
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < N_STAGES; i++) begin
            pipe_ff[i] <= pipe_in[i];
         end
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N_STAGES; i++) begin
            valid_ff[i] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff[ST_IN] <= req_valid;
         for (int i = 1; i < N_STAGES; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
         rsp_valid_ff <= valid_ff[N_STAGES-1]
                         && (pipe_ff[N_STAGES-1].func == FUNC_COMPUTE);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
endmodule

/* src/brr_ram.sv */
`timescale 1ns / 1ps
// brr_ram: generic single-port RAM, registered read.
// No dependencies.
module brr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;
endmodule

/* src/brr_checker.sv */
`timescale 1ns / 1ps
// brr_checker: port-level checks on bilinear_rgba_resize, bound to the top.
// Uses brr_pkg.
module brr_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input brr_pkg::rsp_type rsp_item
);
   import brr_pkg::*;

   // input side only backs up when a result is waiting
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("req_stall without a blocked result");

   // out-of-range results carry no color
   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status == STATUS_RANGE) |->
      (rsp_item.out_red == '0 && rsp_item.out_green == '0 &&
       rsp_item.out_blue == '0 && rsp_item.out_alpha == '0))
      else $error("range status with nonzero color");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_item)))
      else $error("stalled result changed");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");
endmodule

bind bilinear_rgba_resize brr_checker u_brr_checker (.*);

/* tb/bilinear_rgba_resize_test.sv */
`timescale 1ns / 1ps
// bilinear_rgba_resize_test: self-checking bench for the bilinear RGBA resizer.
// Depends on brr_pkg and bilinear_rgba_resize; predicts every result on its own.
module bilinear_rgba_resize_test;
   import brr_pkg::*;

   localparam int LATENCY = 22;

   // one pending item on the input side, with an optional typed-in answer
   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } send_entry_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_item = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_item;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   bilinear_rgba_resize uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow of the block: size registers and pixel store (byte 0 = red)
   logic [7:0]       src_w_reg = 8'd1;
   logic [7:0]       src_h_reg = 8'd1;
   logic [11:0]      dst_w_reg = '0;
   logic [11:0]      dst_h_reg = '0;
   logic [3:0][7:0]  pix_shadow [MAX_SOURCE_WIDTH*MAX_SOURCE_HEIGHT];

   send_entry_type send_q[$];
   rsp_type   pixel_due[$];   // results still owed by the block
   int        send_idle = 0;  // percent of cycles the sender holds off
   int        recv_stall = 0; // percent of cycles the receiver stalls
   int        errors = 0;
   int        n_items = 0;
   int        n_results = 0;

   function automatic int eff_size(logic [7:0] v, int maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   // map one destination coordinate onto the source axis
   function automatic void map_axis(input int pos, input int src, input int dst,
                                    output int i0, output int i1, output longint f);
      longint num, den, base;
      num = (2 * longint'(pos) + 1) * src - dst;
      den = 2 * longint'(dst);
      if (num < 0) begin
         base = 0;
         f = 0;
      end else begin
         base = num / den;
         if (base > src - 1) base = src - 1;
         f = num - base * den;
         if (f > den) f = den;
      end
      i0 = int'(base);
      i1 = (i0 + 1 < src) ? i0 + 1 : src - 1;
   endfunction

   function automatic rsp_type blend_pixel(int px, int py);
      int sw, sh, dw, dh, x0, x1, y0, y1;
      longint fx, fy, dx, dy, den, top, bot, sum, v;
      logic [3:0][7:0] p00, p10, p01, p11, res;
      rsp_type r;
      sw = eff_size(src_w_reg, MAX_SOURCE_WIDTH);
      sh = eff_size(src_h_reg, MAX_SOURCE_HEIGHT);
      dw = (dst_w_reg != 0) ? dst_w_reg : sw;
      dh = (dst_h_reg != 0) ? dst_h_reg : sh;
      r = '0;
      if (px >= dw || py >= dh) begin
         r.status = STATUS_RANGE;
         return r;
      end
      map_axis(px, sw, dw, x0, x1, fx);
      map_axis(py, sh, dh, y0, y1, fy);
      dx = 2 * dw;
      dy = 2 * dh;
      den = dx * dy;
      p00 = pix_shadow[y0 * MAX_SOURCE_WIDTH + x0];
      p10 = pix_shadow[y0 * MAX_SOURCE_WIDTH + x1];
      p01 = pix_shadow[y1 * MAX_SOURCE_WIDTH + x0];
      p11 = pix_shadow[y1 * MAX_SOURCE_WIDTH + x1];
      for (int c = 0; c < 4; c++) begin
         top = p00[c] * (dx - fx) + p10[c] * fx;
         bot = p01[c] * (dx - fx) + p11[c] * fx;
         sum = top * (dy - fy) + bot * fy;
         v = (sum + den / 2) / den;
         if (v > 255) v = 255;
         res[c] = v[7:0];
      end
      r.out_red = res[0];
      r.out_green = res[1];
      r.out_blue = res[2];
      r.out_alpha = res[3];
      r.status = STATUS_OK;
      return r;
   endfunction

   // item accepted: update shadow store or queue the expected pixel
   task automatic take_item(send_entry_type e);
      int sw, sh;
      rsp_type r;
      sw = eff_size(src_w_reg, MAX_SOURCE_WIDTH);
      sh = eff_size(src_h_reg, MAX_SOURCE_HEIGHT);
      n_items++;
      if (e.item.func == FUNC_LOAD) begin
         if (e.item.pos_x < sw && e.item.pos_y < sh)
            pix_shadow[e.item.pos_y * MAX_SOURCE_WIDTH + e.item.pos_x] =
               {e.item.in_alpha, e.item.in_blue, e.item.in_green, e.item.in_red};
      end else begin
         r = blend_pixel(e.item.pos_x, e.item.pos_y);
         pixel_due.push_back(e.typed ? e.want : r);
      end
   endtask

   task automatic report_mismatch(string what, rsp_type got, rsp_type want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // sender: holds a stalled item steady, otherwise may idle at random
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            take_item(send_q[0]);
            void'(send_q.pop_front());
         end
         if (!(req_valid && req_stall)) begin
            if (send_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
               req_valid <= 1'b1;
               req_item <= send_q[0].item;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: checks each accepted result against the oldest expectation
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            n_results++;
            if (pixel_due.size() == 0) begin
               report_mismatch("unexpected item", rsp_item, '0);
            end else begin
               if (rsp_item.out_red !== pixel_due[0].out_red)
                  report_mismatch("red", rsp_item, pixel_due[0]);
               if (rsp_item.out_green !== pixel_due[0].out_green)
                  report_mismatch("green", rsp_item, pixel_due[0]);
               if (rsp_item.out_blue !== pixel_due[0].out_blue)
                  report_mismatch("blue", rsp_item, pixel_due[0]);
               if (rsp_item.out_alpha !== pixel_due[0].out_alpha)
                  report_mismatch("alpha", rsp_item, pixel_due[0]);
               if (rsp_item.status !== pixel_due[0].status)
                  report_mismatch("status", rsp_item, pixel_due[0]);
               void'(pixel_due.pop_front());
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_stall);
      end
   end

   task automatic csr_write(reg_index_type idx, logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= 4'(idx) << 2;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_SOURCE_WIDTH:  src_w_reg = value[7:0];
         REG_SOURCE_HEIGHT: src_h_reg = value[7:0];
         REG_TARGET_WIDTH:  dst_w_reg = value[11:0];
         REG_TARGET_HEIGHT: dst_h_reg = value[11:0];
         default: ;
      endcase
   endtask

   // wait for all items out, all results back, then the pipeline tail
   task automatic drain;
      while (send_q.size() > 0 || req_valid || pixel_due.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   function automatic send_entry_type mk_item(func_type f, int x, int y, logic [31:0] rgba);
      send_entry_type e;
      e.item.func = f;
      e.item.pos_x = 12'(x);
      e.item.pos_y = 12'(y);
      {e.item.in_red, e.item.in_green, e.item.in_blue, e.item.in_alpha} = rgba;
      e.typed = 1'b0;
      e.want = '0;
      return e;
   endfunction

   // directed rows: {func, x, y, rgba, typed?, expected rgba, expected status}
   typedef struct {
      func_type    f;
      int          x;
      int          y;
      logic [31:0] rgba;
      bit          typed;
      logic [31:0] want_rgba;
      logic        want_status;
   } row_type;

   row_type rows[] = '{
      '{FUNC_LOAD,    0,    0,    32'hFF008001, 0, 32'h0, STATUS_OK},
      '{FUNC_COMPUTE, 0,    0,    32'h0,        1, 32'hFF008001, STATUS_OK},
      '{FUNC_COMPUTE, 1,    0,    32'hFFFFFFFF, 1, 32'h0, STATUS_RANGE},
      '{FUNC_COMPUTE, 0,    1,    32'h0,        1, 32'h0, STATUS_RANGE},
      '{FUNC_COMPUTE, 4095, 4095, 32'hFFFFFFFF, 1, 32'h0, STATUS_RANGE},
      // loads outside the source are dropped
      '{FUNC_LOAD,    1,    0,    32'h12345678, 0, 32'h0, STATUS_OK},
      '{FUNC_LOAD,    4095, 4095, 32'hFFFFFFFF, 0, 32'h0, STATUS_OK},
      '{FUNC_COMPUTE, 0,    0,    32'h0,        1, 32'hFF008001, STATUS_OK},
      '{FUNC_LOAD,    0,    0,    32'hFFFFFFFF, 0, 32'h0, STATUS_OK},
      '{FUNC_COMPUTE, 0,    0,    32'h0,        1, 32'hFFFFFFFF, STATUS_OK},
      '{FUNC_LOAD,    0,    0,    32'h00000000, 0, 32'h0, STATUS_OK},
      '{FUNC_COMPUTE, 0,    0,    32'h0,        1, 32'h00000000, STATUS_OK},
      '{FUNC_LOAD,    0,    0,    32'h7F80A55A, 0, 32'h0, STATUS_OK},
      '{FUNC_COMPUTE, 0,    0,    32'h0,        0, 32'h0, STATUS_OK},
      '{FUNC_COMPUTE, 2048, 0,    32'h0,        1, 32'h0, STATUS_RANGE}
   };

   // random phases: source w/h (0 and >128 test the clamp), target w/h
   int phase_cfg[][4] = '{
      '{2, 2, 0, 0}, '{16, 1, 4095, 1}, '{1, 200, 1, 4095}, '{3, 5, 7, 2},
      '{0, 3, 0, 0}, '{8, 8, 3, 5}, '{5, 7, 1, 1}, '{4, 3, 9, 13},
      '{255, 1, 100, 2}, '{6, 6, 0, 0}, '{1, 1, 4095, 4095}, '{7, 2, 2, 7}
   };
   int idle_cfg[][2] = '{'{0, 0}, '{58, 0}, '{0, 58}, '{19, 19}};

   initial begin
      send_entry_type e;
      int sw, sh, dw, dh, n;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         e = mk_item(rows[i].f, rows[i].x, rows[i].y, rows[i].rgba);
         if (rows[i].typed) begin
            e.typed = 1'b1;
            {e.want.out_red, e.want.out_green, e.want.out_blue, e.want.out_alpha} =
               rows[i].want_rgba;
            e.want.status = rows[i].want_status;
         end
         send_q.push_back(e);
      end
      drain();

      foreach (phase_cfg[p]) begin
         send_idle = idle_cfg[p % 4][0];
         recv_stall = idle_cfg[p % 4][1];
         csr_write(REG_SOURCE_WIDTH, phase_cfg[p][0]);
         csr_write(REG_SOURCE_HEIGHT, phase_cfg[p][1]);
         csr_write(REG_TARGET_WIDTH, phase_cfg[p][2]);
         csr_write(REG_TARGET_HEIGHT, phase_cfg[p][3]);
         sw = eff_size(src_w_reg, MAX_SOURCE_WIDTH);
         sh = eff_size(src_h_reg, MAX_SOURCE_HEIGHT);
         dw = (dst_w_reg != 0) ? dst_w_reg : sw;
         dh = (dst_h_reg != 0) ? dst_h_reg : sh;
         // fill the whole source first so no compute touches an unwritten entry
         for (int y = 0; y < sh; y++)
            for (int x = 0; x < sw; x++)
               send_q.push_back(mk_item(FUNC_LOAD, x, y, $urandom));
         for (n = 0; n < 20; n++) begin
            case ($urandom_range(0, 9))
               0, 1:    e = mk_item(FUNC_LOAD, $urandom_range(0, sw - 1),
                                    $urandom_range(0, sh - 1), $urandom);
               2:       e = mk_item(FUNC_LOAD, $urandom_range(0, 4095),
                                    $urandom_range(0, 4095), $urandom);
               3:       e = mk_item(FUNC_COMPUTE, $urandom_range(0, 4095),
                                    $urandom_range(0, 4095), $urandom);
               default: e = mk_item(FUNC_COMPUTE, $urandom_range(0, dw - 1),
                                    $urandom_range(0, dh - 1), $urandom);
            endcase
            send_q.push_back(e);
         end
         drain();
      end

      $display("covered %0d items and %0d results over %0d size settings",
               n_items, n_results, phase_cfg.size() + 1);
      if (pixel_due.size() != 0) begin
         $display("%0d results never arrived", pixel_due.size());
         errors++;
      end
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("timeout at %0t", $realtime);
      $display("TB_ERROR");
      $finish;
   end

endmodule
